@@ rtl/ssm_pkg.sv @@
package ssm_pkg;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_MASK   = 3'd3;
  localparam logic [2:0] ACT_VELS   = 3'd4;

  localparam logic [3:0] LAST_STEP_OUT = 4'd15;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_CP_RD,
    ST_CP_WR,
    ST_COMMIT,
    ST_VQ_RD,
    ST_VQ_OUT
  } ssm_state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RUN,
    RES_WORD,
    RES_MASK,
    RES_VEL
  } ssm_res_t;

  typedef struct packed {
    logic     load;
    logic     mem_rd;
    logic     sample_exec;
    logic     run_end;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     cp_rd;
    logic     cp_wr;
    logic     vel_set;
    logic     vel_zero;
    logic     clr_wr;
    logic     vq_rd;
    logic     success;
    ssm_res_t emit;
  } ssm_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       last;
    logic       commit_ok;
    logic       rm_ok;
    logic       clear_end;
    logic       copy_end;
    logic       vq_end;
  } ssm_status_t;

endpackage

@@ rtl/ssm_ctrl.sv @@
module ssm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ssm_pkg::ssm_status_t sts,
  output ssm_pkg::ssm_cmd_t   cmd,
  output logic                busy
);
  import ssm_pkg::*;

  ssm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = RES_NONE;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.clear_end) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        priority case (sts.act)
          ACT_ADD: begin
            cmd.sample_exec = 1'b1;
            if (sts.last) begin
              if (sts.commit_ok) begin
                cmd.cnt_clr = 1'b1;
                state_nxt   = ST_CP_RD;
              end else begin
                cmd.run_end = 1'b1;
                cmd.emit    = RES_RUN;
              end
            end
          end
          ACT_REMOVE: begin
            cmd.sample_exec = 1'b1;
            if (sts.last) begin
              cmd.run_end  = 1'b1;
              cmd.emit     = RES_RUN;
              cmd.success  = sts.rm_ok;
              cmd.vel_zero = sts.rm_ok;
            end
          end
          ACT_READ: cmd.emit = RES_WORD;
          ACT_MASK: cmd.emit = RES_MASK;
          ACT_VELS: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_VQ_RD;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_CP_RD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd.cp_wr   = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.copy_end ? ST_COMMIT : ST_CP_RD;
      end
      ST_COMMIT: begin
        cmd.vel_set = 1'b1;
        cmd.emit    = RES_RUN;
        cmd.success = 1'b1;
        cmd.run_end = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_VQ_RD: begin
        cmd.vq_rd = 1'b1;
        state_nxt = ST_VQ_OUT;
      end
      ST_VQ_OUT: begin
        cmd.emit    = RES_VEL;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.vq_end ? ST_IDLE : ST_VQ_RD;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

@@ rtl/ssm_datapath.sv @@
module ssm_datapath #(
  parameter int NUM_STEPS  = 16,
  parameter int NUM_SOUNDS = 8,
  parameter int BUFFER_LEN = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssm_pkg::ssm_cmd_t    cmd,
  output ssm_pkg::ssm_status_t sts,
  input  logic [2:0]           in_action,
  input  logic [3:0]           in_step_index,
  input  logic [2:0]           in_sound_index,
  input  logic [3:0]           in_velocity,
  input  logic signed [15:0]   in_sound_sample,
  input  logic [13:0]          in_position,
  input  logic                 in_run_last,
  output logic                 out_valid,
  output logic signed [15:0]   out_mixed_word,
  output logic                 out_success,
  output logic [7:0]           out_sound_mask,
  output logic [3:0]           out_velocity_out,
  output logic [3:0]           out_step_out,
  output logic                 out_last_result
);
  import ssm_pkg::*;

  localparam int DEPTH = NUM_STEPS * BUFFER_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int NW    = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam int BW    = $clog2(BUFFER_LEN);
  localparam int PW    = $clog2(BUFFER_LEN + 1);

  // trunc(sample * vel / 8) toward zero
  function automatic logic signed [17:0] scale_vel(input logic signed [15:0] s,
                                                   input logic [3:0] v);
    logic signed [20:0] p;
    logic signed [20:0] adj;
    begin
      p   = 21'(s) * signed'({17'd0, v});
      adj = p + ((p < 0) ? 21'sd7 : 21'sd0);
      return 18'(adj >>> 3);
    end
  endfunction

  logic [15:0] mix_mem [DEPTH];
  logic [15:0] cand_mem [BUFFER_LEN];
  logic [NUM_SOUNDS-1:0][3:0] vel_mem [NUM_STEPS];

  logic [2:0]         act_r;
  logic [3:0]         step_r;
  logic [2:0]         sound_r;
  logic [3:0]         vel_r;
  logic signed [15:0] sample_r;
  logic [13:0]        pos_r;
  logic               last_r;

  logic [PW-1:0] rp_r, rp_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;

  logic [15:0]                mix_rd_r;
  logic [15:0]                cand_rd_r;
  logic [NUM_SOUNDS-1:0][3:0] vel_row_r;

  logic               out_valid_r, out_success_r, out_last_r;
  logic signed [15:0] out_word_r;
  logic [7:0]         out_mask_r;
  logic [3:0]         out_vel_r, out_step_r;

  logic          step_ok, sound_ok, item_ok, pos_ok, t_ok, hit;
  logic [SW-1:0] step_idx;
  logic [NW-1:0] snd_idx;
  logic [AW-1:0] base, smp_addr, mix_wa;
  logic [15:0]   mix_wd;
  logic          mix_we;
  logic [3:0]    oldv;
  logic signed [17:0] oldc, newc;
  logic signed [18:0] add_w;
  logic          add_ovf;
  logic [15:0]   rm_w;
  logic [7:0]    mask_bits;
  logic          vq_ok;

  assign step_ok  = 32'(step_r) < NUM_STEPS;
  assign sound_ok = 32'(sound_r) < NUM_SOUNDS;
  assign item_ok  = step_ok && sound_ok;
  assign pos_ok   = 32'(pos_r) < BUFFER_LEN;
  assign t_ok     = 32'(rp_r) < BUFFER_LEN;
  assign hit      = item_ok && t_ok;
  assign step_idx = SW'(step_r);
  assign snd_idx  = NW'(sound_r);
  assign base     = AW'(step_r) * AW'(BUFFER_LEN);
  assign smp_addr = (act_r == ACT_READ) ? base + AW'(pos_r) : base + AW'(rp_r);

  assign oldv  = item_ok ? vel_row_r[snd_idx] : 4'd0;
  assign oldc  = scale_vel(sample_r, oldv);
  assign newc  = scale_vel(sample_r, vel_r);
  assign add_w = 19'(signed'(mix_rd_r)) - 19'(oldc) + 19'(newc);
  assign add_ovf = (add_w > 19'sd32767) || (add_w < -19'sd32768);
  assign rm_w  = mix_rd_r - oldc[15:0];
  assign vq_ok = (32'(cnt_r) < NUM_STEPS) && sound_ok;

  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < NUM_SOUNDS) begin : g_on
      assign mask_bits[g] = (vel_row_r[g] != 4'd0);
    end else begin : g_off
      assign mask_bits[g] = 1'b0;
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      step_r   <= in_step_index;
      sound_r  <= in_sound_index;
      vel_r    <= in_velocity;
      sample_r <= in_sound_sample;
      pos_r    <= in_position;
      last_r   <= in_run_last;
    end
  end

  always_comb begin
    rp_nxt  = rp_r;
    ovf_nxt = ovf_r;
    if (cmd.sample_exec) begin
      if (t_ok) begin
        rp_nxt = rp_r + PW'(1);
      end
      if (hit && act_r == ACT_ADD && add_ovf) begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.run_end) begin
      rp_nxt  = '0;
      ovf_nxt = 1'b0;
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + AW'(1);
    end
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      rp_r  <= rp_nxt;
      ovf_r <= ovf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // mix buffer write port select
  always_comb begin
    mix_we = 1'b0;
    mix_wa = cnt_r;
    mix_wd = 16'd0;
    if (cmd.clr_wr) begin
      mix_we = 1'b1;
    end else if (cmd.cp_wr) begin
      mix_we = 1'b1;
      mix_wa = base + cnt_r;
      mix_wd = cand_rd_r;
    end else if (cmd.sample_exec && hit && act_r == ACT_REMOVE) begin
      mix_we = 1'b1;
      mix_wa = smp_addr;
      mix_wd = rm_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_we) begin
      mix_mem[mix_wa] <= mix_wd;
    end
    if (cmd.mem_rd) begin
      mix_rd_r <= mix_mem[smp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_exec && hit && act_r == ACT_ADD) begin
      cand_mem[rp_r[BW-1:0]] <= add_w[15:0];
    end
    if (cmd.cp_rd) begin
      cand_rd_r <= cand_mem[cnt_r[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr && 32'(cnt_r) < NUM_STEPS) begin
      vel_mem[SW'(cnt_r)] <= '0;
    end else if (cmd.vel_set) begin
      vel_mem[step_idx][snd_idx] <= vel_r;
    end else if (cmd.vel_zero) begin
      vel_mem[step_idx][snd_idx] <= 4'd0;
    end
    if (cmd.mem_rd) begin
      vel_row_r <= vel_mem[step_idx];
    end else if (cmd.vq_rd) begin
      vel_row_r <= vel_mem[SW'(cnt_r)];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    out_word_r    <= '0;
    out_success_r <= 1'b0;
    out_mask_r    <= '0;
    out_vel_r     <= '0;
    out_step_r    <= '0;
    out_last_r    <= 1'b1;
    unique case (cmd.emit)
      RES_RUN:  out_success_r <= cmd.success;
      RES_WORD: out_word_r    <= (step_ok && pos_ok) ? signed'(mix_rd_r) : 16'sd0;
      RES_MASK: out_mask_r    <= step_ok ? mask_bits : 8'd0;
      RES_VEL: begin
        out_vel_r  <= vq_ok ? vel_row_r[NW'(sound_r)] : 4'd0;
        out_step_r <= cnt_r[3:0];
        out_last_r <= (cnt_r[3:0] == LAST_STEP_OUT);
      end
      default: out_last_r <= 1'b0;
    endcase
  end

  assign sts.act       = act_r;
  assign sts.last      = last_r;
  assign sts.commit_ok = item_ok && !(ovf_r || (hit && add_ovf)) && (oldv != vel_r);
  assign sts.rm_ok     = item_ok && (oldv != 4'd0);
  assign sts.clear_end = (32'(cnt_r) == DEPTH - 1);
  assign sts.copy_end  = (32'(cnt_r) + 1 == 32'(rp_r));
  assign sts.vq_end    = (cnt_r[3:0] == LAST_STEP_OUT);

  assign out_valid        = out_valid_r;
  assign out_mixed_word   = out_word_r;
  assign out_success      = out_success_r;
  assign out_sound_mask   = out_mask_r;
  assign out_velocity_out = out_vel_r;
  assign out_step_out     = out_step_r;
  assign out_last_result  = out_last_r;

endmodule

@@ rtl/step_sample_mixer_unit.sv @@
// channel   | handshake                 | payload
// request   | start / busy              | in_action .. in_run_last
// result    | out_valid (strobe)        | out_mixed_word .. out_last_result
//
// a sample request goes through latch, registered read of the mix word and
// velocity row, then compute and write back
// the last request of a successful add run copies the candidate words into
// the step buffer word by word, each read then written (one memory read port, one write port)
// a sound velocity query gives 16 results, each from a registered read of one step's velocity row
// after reset busy stays high while the NUM_STEPS * BUFFER_LEN word
// mix buffer is cleared one word a cycle
// results are strobed for one cycle; the receiver cannot stall
module step_sample_mixer_unit #(
  parameter int NUM_STEPS  = 16,
  parameter int NUM_SOUNDS = 8,
  parameter int BUFFER_LEN = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [3:0]         in_step_index,
  input  logic [2:0]         in_sound_index,
  input  logic [3:0]         in_velocity,
  input  logic signed [15:0] in_sound_sample,
  input  logic [13:0]        in_position,
  input  logic               in_run_last,
  output logic               out_valid,
  output logic signed [15:0] out_mixed_word,
  output logic               out_success,
  output logic [7:0]         out_sound_mask,
  output logic [3:0]         out_velocity_out,
  output logic [3:0]         out_step_out,
  output logic               out_last_result
);
  import ssm_pkg::*;

  ssm_cmd_t    cmd;
  ssm_status_t sts;

  // sequencing of reads, writes, the commit copy and the query walk
  ssm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // stores, scaling arithmetic and the result register
  ssm_datapath #(
    .NUM_STEPS  (NUM_STEPS),
    .NUM_SOUNDS (NUM_SOUNDS),
    .BUFFER_LEN (BUFFER_LEN)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_step_index    (in_step_index),
    .in_sound_index   (in_sound_index),
    .in_velocity      (in_velocity),
    .in_sound_sample  (in_sound_sample),
    .in_position      (in_position),
    .in_run_last      (in_run_last),
    .out_valid        (out_valid),
    .out_mixed_word   (out_mixed_word),
    .out_success      (out_success),
    .out_sound_mask   (out_sound_mask),
    .out_velocity_out (out_velocity_out),
    .out_step_out     (out_step_out),
    .out_last_result  (out_last_result)
  );

endmodule

@@ rtl/ssm_checker.sv @@
module ssm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_mixed_word,
  input logic               out_success,
  input logic               out_last_result
);

  // clearing pass holds requests off after reset
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_query_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> !out_valid)
    else $error("velocity results not spaced");

  a_query_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !out_success && out_mixed_word == 16'sd0)
    else $error("stray fields on velocity result");

endmodule

bind step_sample_mixer_unit ssm_checker u_ssm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_mixed_word  (out_mixed_word),
  .out_success     (out_success),
  .out_last_result (out_last_result)
);
